### rtl/kwe_pkg.sv
`default_nettype none

package kwe_pkg;

  // Field and register widths.
  localparam int SAMPLE_W     = 24;
  localparam int CHAN_W       = 4;
  localparam int COEF_W       = 32;
  localparam int DLY_W        = 40;
  localparam int ENERGY_W     = 63;
  localparam int PEAK_W       = 24;
  localparam int WIN_W        = 32;
  localparam int FPW_W        = 16;
  localparam int CNT_W        = 5;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 64;
  localparam int FILTER_ORDER = 4;
  localparam int DEF_MAX_CHANNELS = 16;

  // Filter arithmetic.
  localparam int ROUND_SH  = 28;
  localparam int SQ_W      = 64;
  localparam int Y_W       = 32;

  localparam logic [FPW_W-1:0] FPW_RESET = FPW_W'(19200);
  localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(2);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0_B1 = 3'd0,
    REG_B2_B3 = 3'd1,
    REG_B4_A1 = 3'd2,
    REG_A2_A3 = 3'd3,
    REG_A4    = 3'd4,
    REG_FPW   = 3'd5,
    REG_CNT   = 3'd6
  } cfg_reg_t;

  // One row of filter delay values, element k holds d[k].
  typedef logic [FILTER_ORDER-1:0][DLY_W-1:0] dly_row_t;

  typedef struct packed {
    logic [FILTER_ORDER:0][COEF_W-1:0] b;
    logic [FILTER_ORDER:1][COEF_W-1:0] a;
  } coef_t;

  typedef struct packed {
    logic inc;
    logic sur;
  } slot_t;

  typedef struct packed {
    logic                       start;
    logic                       sur;
    logic signed [SAMPLE_W-1:0] x;
  } flt_req_t;

  typedef struct packed {
    logic                    done;
    logic [DLY_W-1:0]        v0;
    logic [ENERGY_W-1:0]     energy;
  } flt_rsp_t;

  // Speaker layout: whether a channel counts and whether it is a surround slot.
  function automatic slot_t slot_of(input logic [CNT_W-1:0] cnt,
                                    input logic [CHAN_W-1:0] c);
    slot_t s;
    s.inc = 1'b0;
    s.sur = 1'b0;
    if (cnt == CNT_W'(4)) begin
      s.inc = (c < CHAN_W'(4));
      s.sur = (c == CHAN_W'(2)) || (c == CHAN_W'(3));
    end else if (cnt == CNT_W'(5)) begin
      s.inc = (c < CHAN_W'(5));
      s.sur = (c == CHAN_W'(3)) || (c == CHAN_W'(4));
    end else begin
      s.inc = (c <= CHAN_W'(2)) || (c == CHAN_W'(4)) || (c == CHAN_W'(5));
      s.sur = (c == CHAN_W'(4)) || (c == CHAN_W'(5));
    end
    return s;
  endfunction

endpackage

`default_nettype wire

### rtl/kweighted_window_energy_peak_core.sv
// K-weighted window energy and peak meter. Interleaved samples enter one at
// a time on the in_ request channel; each counted channel runs through a
// fourth-order filter whose squared, optionally surround-weighted output is
// summed per channel, and the largest absolute sample is tracked for the
// window. On the sample that ends the last frame of a window, one result per
// channel leaves on the out_ channel, in channel order, with last on the
// final one. A counted sample is worked by the single multiplier, which runs
// the nine filter products one after another, then squaring, weighting and
// the read-modify-write of the delay and energy memories; an excluded or
// ignored sample skips the filter. No new sample is taken until the last one
// is finished, and closing a window reads out and emits each channel in turn.
// Configuration may be written only while the block is idle.
`default_nettype none

module kweighted_window_energy_peak_core #(
  parameter int MAX_CHANNELS = kwe_pkg::DEF_MAX_CHANNELS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [kwe_pkg::SAMPLE_W-1:0] in_sample,
  input  logic [kwe_pkg::CHAN_W-1:0]        in_channel,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [kwe_pkg::CHAN_W-1:0]        out_channel,
  output logic                              out_included,
  output logic [kwe_pkg::ENERGY_W-1:0]      out_energy,
  output logic [kwe_pkg::PEAK_W-1:0]        out_peak,
  output logic [kwe_pkg::WIN_W-1:0]         out_window_index,
  output logic                              out_last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [kwe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [kwe_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import kwe_pkg::*;

  localparam int CH_AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int ROW_W = FILTER_ORDER * DLY_W;

  typedef enum logic [2:0] {S_IDLE, S_RD, S_RUN, S_FRAME, S_EMIT_RD, S_EMIT_WR} state_t;

  // Configuration registers.
  logic [CFG_DATA_W-1:0] b0b1_r, b2b3_r, b4a1_r, a2a3_r;
  logic [COEF_W-1:0]     a4_r;
  logic [FPW_W-1:0]      fpw_r;
  logic [CNT_W-1:0]      cnt_r;

  // Control and window state.
  state_t                state_r;
  logic signed [SAMPLE_W-1:0] x_r;
  logic [CHAN_W-1:0]     ch_r;
  logic                  sur_r;
  logic [CHAN_W-1:0]     emit_idx_r;
  logic [PEAK_W-1:0]     peak_r;
  logic [FPW_W-1:0]      frame_r;
  logic [WIN_W-1:0]      win_r;

  logic                  out_valid_r;
  logic [CHAN_W-1:0]     out_channel_r;
  logic                  out_included_r;
  logic [ENERGY_W-1:0]   out_energy_r;
  logic [PEAK_W-1:0]     out_peak_r;
  logic [WIN_W-1:0]      out_window_index_r;
  logic                  out_last_r;

  logic [CNT_W-1:0]      cnt_eff;
  logic [FPW_W-1:0]      fpw_eff;
  logic [FPW_W:0]        frame_inc;
  logic                  in_acc;
  logic                  in_take;
  slot_t                 in_slot;
  slot_t                 emit_slot;
  logic [PEAK_W-1:0]     in_mag;
  logic                  out_load;
  logic                  emit_end;
  logic                  ch_is_last;

  coef_t                 coef;
  flt_req_t              flt_req;
  flt_rsp_t              flt_rsp;
  dly_row_t              dly_rd;
  logic [ROW_W-1:0]      dly_rd_data;
  logic [ROW_W-1:0]      dly_wr_data;
  logic                  dly_wr_en;
  logic [ENERGY_W-1:0]   e_rd_data;
  logic                  e_rd_en;
  logic [CH_AW-1:0]      e_rd_addr;
  logic                  e_clr;

  // Effective channel count and window length.
  always_comb begin
    if (cnt_r == '0) begin
      cnt_eff = CNT_W'(1);
    end else if (cnt_r > CNT_W'(MAX_CHANNELS)) begin
      cnt_eff = CNT_W'(MAX_CHANNELS);
    end else begin
      cnt_eff = cnt_r;
    end
    fpw_eff = (fpw_r == '0) ? FPW_W'(1) : fpw_r;
  end

  assign in_ready   = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign in_acc     = in_valid && in_ready;
  assign in_take    = in_acc && ({1'b0, in_channel} < cnt_eff);
  assign in_slot    = slot_of(cnt_eff, in_channel);
  assign emit_slot  = slot_of(cnt_eff, emit_idx_r);
  assign in_mag     = in_sample[SAMPLE_W-1] ? PEAK_W'(-in_sample) : PEAK_W'(in_sample);
  assign ch_is_last = ({1'b0, ch_r} == cnt_eff - CNT_W'(1));
  assign frame_inc  = {1'b0, frame_r} + (FPW_W+1)'(1);
  assign out_load   = (state_r == S_EMIT_WR) && (!out_valid_r || out_ready);
  assign emit_end   = ({1'b0, emit_idx_r} == cnt_eff - CNT_W'(1));

  // Coefficient fields as the filter sees them.
  assign coef.b[0] = b0b1_r[63:32];
  assign coef.b[1] = b0b1_r[31:0];
  assign coef.b[2] = b2b3_r[63:32];
  assign coef.b[3] = b2b3_r[31:0];
  assign coef.b[4] = b4a1_r[63:32];
  assign coef.a[1] = b4a1_r[31:0];
  assign coef.a[2] = a2a3_r[63:32];
  assign coef.a[3] = a2a3_r[31:0];
  assign coef.a[4] = a4_r;

  // Filter request and write-back of the shifted delay row.
  assign dly_rd        = dly_row_t'(dly_rd_data);
  assign flt_req.start = (state_r == S_RD);
  assign flt_req.sur   = sur_r;
  assign flt_req.x     = x_r;
  assign dly_wr_en     = (state_r == S_RUN) && flt_rsp.done;
  assign dly_wr_data   = {dly_rd[2], dly_rd[1], dly_rd[0], flt_rsp.v0};

  // Energy memory read: the sample's channel on intake, each channel on output.
  assign e_rd_en   = (in_take && in_slot.inc) || (state_r == S_EMIT_RD);
  assign e_rd_addr = (state_r == S_EMIT_RD) ? emit_idx_r[CH_AW-1:0] : in_channel[CH_AW-1:0];
  assign e_clr     = out_load && emit_end;

  kwe_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_CHANNELS)
  ) u_dly_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (1'b0),
    .rd_en   (in_take && in_slot.inc),
    .rd_addr (in_channel[CH_AW-1:0]),
    .rd_data (dly_rd_data),
    .wr_en   (dly_wr_en),
    .wr_addr (ch_r[CH_AW-1:0]),
    .wr_data (dly_wr_data)
  );

  kwe_ram #(
    .WIDTH (ENERGY_W),
    .DEPTH (MAX_CHANNELS)
  ) u_energy_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (e_clr),
    .rd_en   (e_rd_en),
    .rd_addr (e_rd_addr),
    .rd_data (e_rd_data),
    .wr_en   (dly_wr_en),
    .wr_addr (ch_r[CH_AW-1:0]),
    .wr_data (flt_rsp.energy)
  );

  kwe_filter u_filter (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (flt_req),
    .dly   (dly_rd),
    .coef  (coef),
    .e_old (e_rd_data),
    .rsp   (flt_rsp)
  );

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0b1_r <= '0;
      b2b3_r <= '0;
      b4a1_r <= '0;
      a2a3_r <= '0;
      a4_r   <= '0;
      fpw_r  <= FPW_RESET;
      cnt_r  <= CNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_B0_B1: b0b1_r <= cfg_data;
        REG_B2_B3: b2b3_r <= cfg_data;
        REG_B4_A1: b4a1_r <= cfg_data;
        REG_A2_A3: a2a3_r <= cfg_data;
        REG_A4:    a4_r   <= cfg_data[COEF_W-1:0];
        REG_FPW:   fpw_r  <= cfg_data[FPW_W-1:0];
        REG_CNT:   cnt_r  <= cfg_data[CNT_W-1:0];
        default:   ;
      endcase
    end
  end

  // Main sequencer with the window state and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      peak_r      <= '0;
      frame_r     <= '0;
      win_r       <= '0;
      emit_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_take) begin
            x_r   <= in_sample;
            ch_r  <= in_channel;
            sur_r <= in_slot.sur;
            if (in_mag > peak_r) begin
              peak_r <= in_mag;
            end
            state_r <= in_slot.inc ? S_RD : S_FRAME;
          end
        end
        S_RD: begin
          state_r <= S_RUN;
        end
        S_RUN: begin
          if (flt_rsp.done) begin
            state_r <= S_FRAME;
          end
        end
        S_FRAME: begin
          if (!ch_is_last) begin
            state_r <= S_IDLE;
          end else if (frame_inc >= {1'b0, fpw_eff}) begin
            emit_idx_r <= '0;
            state_r    <= S_EMIT_RD;
          end else begin
            frame_r <= frame_inc[FPW_W-1:0];
            state_r <= S_IDLE;
          end
        end
        S_EMIT_RD: begin
          state_r <= S_EMIT_WR;
        end
        S_EMIT_WR: begin
          if (out_load) begin
            out_channel_r      <= emit_idx_r;
            out_included_r     <= emit_slot.inc;
            out_energy_r       <= emit_slot.inc ? e_rd_data : '0;
            out_peak_r         <= peak_r;
            out_window_index_r <= win_r;
            out_last_r         <= emit_end;
            if (emit_end) begin
              peak_r  <= '0;
              frame_r <= '0;
              win_r   <= win_r + WIN_W'(1);
              state_r <= S_IDLE;
            end else begin
              emit_idx_r <= emit_idx_r + CHAN_W'(1);
              state_r    <= S_EMIT_RD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_channel      = out_channel_r;
  assign out_included     = out_included_r;
  assign out_energy       = out_energy_r;
  assign out_peak         = out_peak_r;
  assign out_window_index = out_window_index_r;
  assign out_last         = out_last_r;

  // The filter only finishes while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (!rst_n)
    flt_rsp.done |-> (state_r == S_RUN))
    else $error("filter finished outside of the run state");

  // Closing a window restarts the peak and the frame count.
  assert property (@(posedge clk) disable iff (!rst_n)
    e_clr |=> (peak_r == '0) && (frame_r == '0) && (state_r == S_IDLE))
    else $error("window state not restarted after the last result");

  // A new window number appears only right after the last result was loaded.
  assert property (@(posedge clk) disable iff (!rst_n)
    (win_r != $past(win_r)) |-> $past(e_clr))
    else $error("window number changed without a window closing");

  // Memory write-back and the window clear never coincide.
  assert property (@(posedge clk) disable iff (!rst_n)
    dly_wr_en |-> !e_clr)
    else $error("energy write collided with window clear");

endmodule

`default_nettype wire

### rtl/kwe_ram.sv
`default_nettype none

module kwe_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clr,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [WIDTH-1:0] q_r;
  logic             qv_r;

  // Storage array, one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r <= mem[rd_addr];
    end
  end

  // Valid bits make entries that were never written read as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      qv_r  <= 1'b0;
    end else begin
      if (clr) begin
        vld_r <= '0;
      end else if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        qv_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = qv_r ? q_r : '0;

endmodule

`default_nettype wire

### rtl/kwe_filter.sv
`default_nettype none

module kwe_filter (
  input  logic              clk,
  input  logic              rst_n,
  input  kwe_pkg::flt_req_t req,
  input  kwe_pkg::dly_row_t dly,
  input  kwe_pkg::coef_t    coef,
  input  logic [kwe_pkg::ENERGY_W-1:0] e_old,
  output kwe_pkg::flt_rsp_t rsp
);
  import kwe_pkg::*;

  localparam int PROD_W  = COEF_W + DLY_W;
  localparam int RND_W   = PROD_W - ROUND_SH;
  localparam int ACC_W   = RND_W + 2;
  localparam int WT_W    = SQ_W + 8;
  localparam int STEP_B0   = 2 * FILTER_ORDER;
  localparam int STEP_LAST = STEP_B0 + 1;

  typedef enum logic [2:0] {F_IDLE, F_MAC, F_SQ, F_WT, F_SUM} fstate_t;

  fstate_t                    state_r;
  logic [3:0]                 step_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [ACC_W-1:0]    v_acc_r;
  logic signed [ACC_W-1:0]    y_acc_r;
  logic [DLY_W-1:0]           v0_r;
  logic [SQ_W-1:0]            sq_r;
  logic [SQ_W-1:0]            wt_r;
  logic                       sur_r;
  dly_row_t                   dly_r;
  logic [ENERGY_W-1:0]        e_old_r;
  flt_rsp_t                   rsp_r;

  logic signed [COEF_W-1:0]   coef_sel;
  logic signed [DLY_W-1:0]    opnd_sel;
  logic signed [PROD_W-1:0]   prod_rnd;
  logic signed [ACC_W-1:0]    rnd_ext;
  logic signed [DLY_W-1:0]    v_sat;
  logic signed [Y_W-1:0]      y_sat;
  logic [Y_W-1:0]             y_mag;
  logic [WT_W-1:0]            sq_105;
  logic [SQ_W-1:0]            sum;

  // Saturate the feedback sum to the delay width.
  always_comb begin
    if ((&v_acc_r[ACC_W-1:DLY_W-1]) || !(|v_acc_r[ACC_W-1:DLY_W-1])) begin
      v_sat = v_acc_r[DLY_W-1:0];
    end else if (v_acc_r[ACC_W-1]) begin
      v_sat = {1'b1, {(DLY_W-1){1'b0}}};
    end else begin
      v_sat = {1'b0, {(DLY_W-1){1'b1}}};
    end
  end

  // Saturate the output sum to 32 bits and take its magnitude.
  always_comb begin
    if ((&y_acc_r[ACC_W-1:Y_W-1]) || !(|y_acc_r[ACC_W-1:Y_W-1])) begin
      y_sat = y_acc_r[Y_W-1:0];
    end else if (y_acc_r[ACC_W-1]) begin
      y_sat = {1'b1, {(Y_W-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(Y_W-1){1'b1}}};
    end
    y_mag = y_sat[Y_W-1] ? Y_W'(-y_sat) : Y_W'(y_sat);
  end

  // Operand order: a1..a4 on the delays, b1..b4 on the delays, then b0 on v0.
  always_comb begin
    coef_sel = '0;
    opnd_sel = '0;
    case (step_r)
      4'd0: begin coef_sel = coef.a[1]; opnd_sel = dly_r[0]; end
      4'd1: begin coef_sel = coef.a[2]; opnd_sel = dly_r[1]; end
      4'd2: begin coef_sel = coef.a[3]; opnd_sel = dly_r[2]; end
      4'd3: begin coef_sel = coef.a[4]; opnd_sel = dly_r[3]; end
      4'd4: begin coef_sel = coef.b[1]; opnd_sel = dly_r[0]; end
      4'd5: begin coef_sel = coef.b[2]; opnd_sel = dly_r[1]; end
      4'd6: begin coef_sel = coef.b[3]; opnd_sel = dly_r[2]; end
      4'd7: begin coef_sel = coef.b[4]; opnd_sel = dly_r[3]; end
      4'd8: begin coef_sel = coef.b[0]; opnd_sel = v_sat; end
      default: begin coef_sel = '0; opnd_sel = '0; end
    endcase
  end

  // Round each product to Q17.23: add half an LSB and floor.
  assign prod_rnd = prod_r + PROD_W'(1 << (ROUND_SH - 1));
  assign rnd_ext  = {{(ACC_W-RND_W){prod_rnd[PROD_W-1]}}, prod_rnd[PROD_W-1:ROUND_SH]};

  // Surround weight 361/256 is y2 plus floor(y2 * 105 / 256).
  assign sq_105 = (WT_W'(sq_r) << 6) + (WT_W'(sq_r) << 5) + (WT_W'(sq_r) << 3) + WT_W'(sq_r);
  assign sum    = {1'b0, e_old_r} + wt_r;

  // Sequencer for the shared multiplier, squaring and accumulation.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= F_IDLE;
      step_r     <= '0;
      rsp_r.done <= 1'b0;
    end else begin
      rsp_r.done <= (state_r == F_SUM);
      unique case (state_r)
        F_IDLE: begin
          if (req.start) begin
            v_acc_r <= ACC_W'(req.x);
            y_acc_r <= '0;
            step_r  <= '0;
            dly_r   <= dly;
            e_old_r <= e_old;
            sur_r   <= req.sur;
            state_r <= F_MAC;
          end
        end
        F_MAC: begin
          if (step_r <= 4'(STEP_B0)) begin
            prod_r <= coef_sel * opnd_sel;
          end
          if (step_r >= 4'd1) begin
            if (step_r <= 4'(FILTER_ORDER)) begin
              v_acc_r <= v_acc_r - rnd_ext;
            end else begin
              y_acc_r <= y_acc_r + rnd_ext;
            end
          end
          if (step_r == 4'(STEP_B0)) begin
            v0_r <= v_sat;
          end
          if (step_r == 4'(STEP_LAST)) begin
            state_r <= F_SQ;
          end else begin
            step_r <= step_r + 4'd1;
          end
        end
        F_SQ: begin
          sq_r    <= SQ_W'(y_mag) * SQ_W'(y_mag);
          state_r <= F_WT;
        end
        F_WT: begin
          wt_r    <= sur_r ? (sq_r + SQ_W'(sq_105 >> 8)) : sq_r;
          state_r <= F_SUM;
        end
        F_SUM: begin
          rsp_r.v0     <= v0_r;
          rsp_r.energy <= sum[SQ_W-1] ? {ENERGY_W{1'b1}} : sum[ENERGY_W-1:0];
          state_r      <= F_IDLE;
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  assign rsp = rsp_r;

endmodule

`default_nettype wire

### tb/kweighted_window_energy_peak_core_tb.sv
`timescale 1ns / 100ps

module kweighted_window_energy_peak_core_tb;
  import kwe_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic signed [31:0] UNITY = 32'sh1000_0000;
  localparam logic [62:0] ENERGY_TOP = {63{1'b1}};
  localparam int IDLE_LIMIT = 6000;
  localparam int SETTLE_CYCLES = 60;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [SAMPLE_W-1:0] in_sample = '0;
  logic [CHAN_W-1:0] in_channel = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [CHAN_W-1:0] out_channel;
  logic out_included;
  logic [ENERGY_W-1:0] out_energy;
  logic [PEAK_W-1:0] out_peak;
  logic [WIN_W-1:0] out_window_index;
  logic out_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  kweighted_window_energy_peak_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_sample(in_sample), .in_channel(in_channel),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_channel(out_channel), .out_included(out_included),
    .out_energy(out_energy), .out_peak(out_peak),
    .out_window_index(out_window_index), .out_last(out_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // One channel report of a closed window.
  typedef struct {
    logic [CHAN_W-1:0] chan;
    logic inc;
    logic [ENERGY_W-1:0] energy;
    logic [PEAK_W-1:0] peak;
    logic [WIN_W-1:0] win;
    logic last;
  } report_t;

  report_t pending_reports[$];
  int failures = 0;
  bit calm = 1'b0;
  int counted_items = 0;

  // Meter state mirrored by the testbench.
  logic signed [COEF_W-1:0] num_coef [0:4];
  logic signed [COEF_W-1:0] den_coef [0:4];
  logic [15:0] win_frames;
  logic [4:0] chan_cnt;
  logic signed [DLY_W-1:0] delay_line [0:15][0:3];
  logic [ENERGY_W-1:0] chan_energy [0:15];
  logic [PEAK_W-1:0] win_peak;
  logic [15:0] frames_seen;
  logic [WIN_W-1:0] win_count;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    foreach (num_coef[i]) begin
      num_coef[i] = '0;
      den_coef[i] = '0;
    end
    foreach (delay_line[c, k]) delay_line[c][k] = '0;
    foreach (chan_energy[c]) chan_energy[c] = '0;
    win_frames = FPW_RESET;
    chan_cnt = CNT_RESET;
    win_peak = '0;
    frames_seen = '0;
    win_count = '0;
  end

  function automatic int active_channels();
    if (chan_cnt == 0) return 1;
    if (chan_cnt > 16) return 16;
    return chan_cnt;
  endfunction

  // Rounded Q4.28 by Q17.23 product, back to Q17.23.
  function automatic logic signed [79:0] coef_product(logic signed [31:0] c,
                                                      logic signed [79:0] v);
    logic signed [79:0] cw;
    cw = c;
    return (cw * v + (80'sd1 <<< 27)) >>> 28;
  endfunction

  // One filter step of a counted channel, with energy accumulation.
  task automatic filter_sample(int ch, logic signed [23:0] x, bit surround);
    logic signed [79:0] v0, y, d;
    logic [63:0] mag, sq;
    logic [64:0] total;
    v0 = x;
    for (int k = 1; k <= 4; k++) begin
      d = delay_line[ch][k-1];
      v0 = v0 - coef_product(den_coef[k], d);
    end
    if (v0 > 80'sd549755813887) v0 = 80'sd549755813887;
    if (v0 < -80'sd549755813888) v0 = -80'sd549755813888;
    y = coef_product(num_coef[0], v0);
    for (int k = 1; k <= 4; k++) begin
      d = delay_line[ch][k-1];
      y = y + coef_product(num_coef[k], d);
    end
    if (y > 80'sd2147483647) y = 80'sd2147483647;
    if (y < -80'sd2147483648) y = -80'sd2147483648;
    mag = (y < 0) ? 64'(-y) : 64'(y);
    sq = mag * mag;
    if (surround) sq = sq + (sq >> 8) * 105 + (((sq & 64'd255) * 105) >> 8);
    total = {2'b00, chan_energy[ch]} + {1'b0, sq};
    chan_energy[ch] = (total > {2'b00, ENERGY_TOP}) ? ENERGY_TOP : total[62:0];
    for (int k = 3; k > 0; k--) delay_line[ch][k] = delay_line[ch][k-1];
    delay_line[ch][0] = v0[39:0];
  endtask

  // Speaker layout of the effective channel count.
  function automatic bit counts_toward(int n, int c);
    if (n == 4) return c < 4;
    if (n == 5) return c < 5;
    return (c <= 2) || (c == 4) || (c == 5);
  endfunction

  function automatic bit is_surround(int n, int c);
    if (n == 4) return c >= 2;
    if (n == 5) return c >= 3;
    return (c == 4) || (c == 5);
  endfunction

  // Apply one accepted sample and queue the window reports it closes.
  task automatic meter_sample(logic signed [23:0] x, logic [3:0] ch);
    int n;
    logic [15:0] len;
    logic [23:0] mag;
    report_t r;
    n = active_channels();
    len = (win_frames == 0) ? 16'd1 : win_frames;
    if (ch >= n) return;
    counted_items++;
    mag = (x < 0) ? 24'(-x) : 24'(x);
    if (mag > win_peak) win_peak = mag;
    if (counts_toward(n, ch)) filter_sample(ch, x, is_surround(n, ch));
    if (ch != n - 1) return;
    frames_seen++;
    if (frames_seen < len) return;
    for (int c = 0; c < n; c++) begin
      r.chan = CHAN_W'(c);
      r.inc = counts_toward(n, c);
      r.energy = r.inc ? chan_energy[c] : '0;
      r.peak = win_peak;
      r.win = win_count;
      r.last = (c == n - 1);
      pending_reports.push_back(r);
    end
    foreach (chan_energy[c]) chan_energy[c] = '0;
    win_peak = '0;
    frames_seen = '0;
    win_count++;
  endtask

  // Send one sample request, with an occasional idle gap ahead of it.
  task automatic send_sample(logic signed [23:0] x, logic [3:0] ch);
    if (!calm && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= x;
    in_channel <= ch;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    meter_sample(x, ch);
  endtask

  function automatic logic signed [23:0] any_sample();
    return 24'($urandom);
  endfunction

  // One frame of n channels; the final channel always closes it.
  task automatic send_frame(int n, bit shuffled);
    int order[$];
    for (int c = 0; c < n - 1; c++) order.push_back(c);
    if (shuffled) order.shuffle();
    foreach (order[i]) send_sample(any_sample(), 4'(order[i]));
    send_sample(any_sample(), 4'(n - 1));
  endtask

  // Wait for every report, then let any sample still in flight finish.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write request; only issued while the meter is idle.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_B0_B1: begin num_coef[0] = value[63:32]; num_coef[1] = value[31:0]; end
      REG_B2_B3: begin num_coef[2] = value[63:32]; num_coef[3] = value[31:0]; end
      REG_B4_A1: begin num_coef[4] = value[63:32]; den_coef[1] = value[31:0]; end
      REG_A2_A3: begin den_coef[2] = value[63:32]; den_coef[3] = value[31:0]; end
      REG_A4:    den_coef[4] = value[31:0];
      REG_FPW:   win_frames = value[15:0];
      REG_CNT:   chan_cnt = value[4:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_filter(logic signed [31:0] b0, logic signed [31:0] b1,
                             logic signed [31:0] b2, logic signed [31:0] b3,
                             logic signed [31:0] b4, logic signed [31:0] a1,
                             logic signed [31:0] a2, logic signed [31:0] a3,
                             logic signed [31:0] a4);
    write_reg(REG_B0_B1, {b0, b1});
    write_reg(REG_B2_B3, {b2, b3});
    write_reg(REG_B4_A1, {b4, a1});
    write_reg(REG_A2_A3, {a2, a3});
    write_reg(REG_A4, {32'h0, a4});
  endtask

  function automatic logic signed [31:0] gentle_coef();
    return $signed(32'($urandom_range(32'h1000_0000))) - 32'sh0800_0000;
  endfunction

  // Pass-through filter: sample extremes, ignored channels, frame order.
  task automatic test_extremes();
    load_filter(UNITY, 0, 0, 0, 0, 0, 0, 0, 0);
    write_reg(REG_FPW, 64'd1);
    write_reg(REG_CNT, 64'd2);
    send_sample(-24'sd8388608, 0);
    send_sample(24'sd8388607, 1);
    send_sample(24'sd0, 15);
    send_sample(24'sd0, 0);
    send_sample(24'sd0, 1);
    send_sample(24'sd8388607, 1);
    send_sample(-24'sd1, 0);
    send_sample(24'sd5, 1);
    settle();
  endtask

  // Every channel layout, counts clamped at both ends.
  task automatic test_layouts();
    int counts[$] = '{4, 5, 6, 3, 16, 0, 31, 1};
    int n;
    load_filter(UNITY, 32'sh0400_0000, 0, 0, 0, -32'sh0800_0000, 0, 0, 0);
    write_reg(REG_FPW, 64'd2);
    foreach (counts[i]) begin
      write_reg(REG_CNT, 64'(counts[i]));
      n = active_channels();
      repeat (2) send_frame(n, 1'b1);
      settle();
    end
  endtask

  // Saturating filter state, filter output and window energy.
  task automatic test_saturation();
    load_filter(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                32'sh8000_0000);
    write_reg(REG_CNT, 64'd5);
    write_reg(REG_FPW, 64'd6);
    repeat (6) begin
      for (int c = 0; c < 5; c++) send_sample(-24'sd8388608, 4'(c));
    end
    settle();
  endtask

  // Shortened window closes at the next frame end; zero length means one.
  task automatic test_window_length();
    load_filter(UNITY, 0, 0, 0, 0, 0, 0, 0, 0);
    write_reg(REG_CNT, 64'd2);
    write_reg(REG_FPW, 64'd65535);
    repeat (4) send_frame(2, 1'b0);
    settle();
    write_reg(REG_FPW, 64'd2);
    write_reg(REG_UNUSED, {64{1'b1}});
    send_frame(2, 1'b0);
    settle();
    write_reg(REG_FPW, 64'd0);
    send_frame(2, 1'b0);
    send_frame(2, 1'b1);
    settle();
  endtask

  // Random settings, mostly well-formed frames with some stray samples.
  task automatic test_random();
    int n;
    int quota;
    for (int phase = 0; phase < 6; phase++) begin
      calm = (phase == 2);
      if (phase == 5) begin
        write_reg(REG_B0_B1, {$urandom, $urandom});
        write_reg(REG_B2_B3, {$urandom, $urandom});
        write_reg(REG_B4_A1, {$urandom, $urandom});
        write_reg(REG_A2_A3, {$urandom, $urandom});
        write_reg(REG_A4, {$urandom, $urandom});
      end else begin
        load_filter(UNITY + gentle_coef(), gentle_coef(), gentle_coef(), gentle_coef(),
                    gentle_coef(), gentle_coef(), gentle_coef() >>> 2,
                    gentle_coef() >>> 3, gentle_coef() >>> 4);
      end
      write_reg(REG_CNT, 64'($urandom_range(31)));
      write_reg(REG_FPW, 64'($urandom_range(4)));
      n = active_channels();
      quota = counted_items + 22;
      while (counted_items < quota) begin
        if ($urandom_range(99) < 12) send_sample(any_sample(), 4'($urandom));
        else send_frame(n, $urandom_range(1));
      end
      settle();
    end
    calm = 1'b0;
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      failures++;
    end
  endtask

  // Compare each accepted report with the oldest one predicted.
  always @(posedge clk) begin
    report_t r;
    if (rst_n && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected report, expected none, got channel %0d", $time,
                 out_channel);
        failures++;
      end else begin
        r = pending_reports.pop_front();
        check_field("out_channel", r.chan, out_channel);
        check_field("out_included", r.inc, out_included);
        check_field("out_energy", r.energy, out_energy);
        check_field("out_peak", r.peak, out_peak);
        check_field("out_window_index", r.win, out_window_index);
        check_field("out_last", r.last, out_last);
      end
    end
  end

  // Result-side back-pressure.
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 10);
  end

  // Stall watchdog: cycles with no accepted request on any channel.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("kweighted_window_energy_peak_core test failed");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_layouts();
    test_saturation();
    test_window_length();
    test_random();
    settle();
    if (failures == 0) begin
      $display("kweighted_window_energy_peak_core test passed");
    end else begin
      $display("kweighted_window_energy_peak_core test failed");
    end
    $finish;
  end

endmodule
